// ===== rtl/eulq_pkg.sv =====
package eulq_pkg;

   localparam int ANGLE_W = 16;
   localparam int QUAT_W = 16;
   localparam int TURN_W = 32;
   localparam int CORDIC_W = 34;
   localparam int SC_W = 32;
   localparam int INT_FRAC = 30;
   localparam int ATAN_LEN = 24;

   localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;

   typedef struct packed {
      logic signed [SC_W-1:0] sine;
      logic signed [SC_W-1:0] cosine;
   } sincos_type;

   // atan(2^-i) in binary angle units, 2^32 per turn
   function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [4:0] idx);
      logic signed [CORDIC_W-1:0] val;
      unique case (idx)
         5'd0:    val = 34'sh20000000;
         5'd1:    val = 34'sh12E4051E;
         5'd2:    val = 34'sh09FB385B;
         5'd3:    val = 34'sh051111D4;
         5'd4:    val = 34'sh028B0D43;
         5'd5:    val = 34'sh0145D7E1;
         5'd6:    val = 34'sh00A2F61E;
         5'd7:    val = 34'sh00517C55;
         5'd8:    val = 34'sh0028BE53;
         5'd9:    val = 34'sh00145F2F;
         5'd10:   val = 34'sh000A2F98;
         5'd11:   val = 34'sh000517CC;
         5'd12:   val = 34'sh00028BE6;
         5'd13:   val = 34'sh000145F3;
         5'd14:   val = 34'sh0000A2FA;
         5'd15:   val = 34'sh0000517D;
         5'd16:   val = 34'sh000028BE;
         5'd17:   val = 34'sh0000145F;
         5'd18:   val = 34'sh00000A30;
         5'd19:   val = 34'sh00000518;
         5'd20:   val = 34'sh0000028C;
         5'd21:   val = 34'sh00000146;
         5'd22:   val = 34'sh000000A3;
         5'd23:   val = 34'sh00000051;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/eulq_angle.sv =====
module eulq_angle (
   input  logic                                  clock,
   input  logic [2:0]                            en,
   input  logic signed [eulq_pkg::ANGLE_W-1:0]   angle,
   output logic signed [eulq_pkg::TURN_W-1:0]    z,
   output logic                                  neg
);

   // half angle in turns: q = mag*93206 + floor((34*mag + 22) / 45)
   localparam logic [33:0] TURN_MUL = 34'd93206;
   localparam logic [20:0] REM_MUL = 21'd34;
   localparam logic [20:0] REM_ADD = 21'd22;
   localparam logic [42:0] RECIP45 = 43'd2982617;
   localparam int RECIP_SH = 27;
   localparam logic signed [31:0] QUARTER_POS = 32'sd1073741824;
   localparam logic signed [31:0] QUARTER_NEG = -32'sd1073741824;

   logic signed [16:0] ext;
   logic [16:0]        mag;
   logic [20:0]        rem_v;
   logic [31:0]        hi_in, hi_ff;
   logic [42:0]        lo_in, lo_ff;
   logic               sg1_in, sg1_ff;
   logic [31:0]        q_in, q_ff;
   logic               sg2_ff;
   logic [31:0]        zs;
   logic signed [31:0] zs_s;
   logic signed [31:0] z_in, z_ff;
   logic               neg_in, neg_ff;

   // stage 1: magnitude and the three constant multiplies
   always_comb begin
      ext = 17'(angle);
      mag = angle[15] ? unsigned'(-ext) : unsigned'(ext);
      rem_v = 21'(mag) * REM_MUL + REM_ADD;
      hi_in = 32'(34'(mag) * TURN_MUL);
      lo_in = 43'(rem_v) * RECIP45;
      sg1_in = angle[15];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
         sg1_ff <= sg1_in;
      end
   end

   // stage 2: quotient
   always_comb begin
      q_in = hi_ff + 32'(lo_ff[42:RECIP_SH]);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         q_ff <= q_in;
         sg2_ff <= sg1_ff;
      end
   end

   // stage 3: restore sign, fold into +-90 degrees
   always_comb begin
      zs = sg2_ff ? (32'd0 - q_ff) : q_ff;
      zs_s = signed'(zs);
      z_in = zs_s;
      neg_in = 1'b0;
      if (zs_s > QUARTER_POS || zs_s < QUARTER_NEG) begin
         z_in = signed'({~zs[31], zs[30:0]});
         neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         z_ff <= z_in;
         neg_ff <= neg_in;
      end
   end

   assign z = z_ff;
   assign neg = neg_ff;

endmodule

// ===== rtl/eulq_cordic.sv =====
module eulq_cordic #(
   parameter int NSTEP = 16
) (
   input  logic                                clock,
   input  logic [NSTEP:0]                      en,
   input  logic signed [eulq_pkg::TURN_W-1:0]  z,
   input  logic                                neg,
   output eulq_pkg::sincos_type                sc
);

   localparam int CW = eulq_pkg::CORDIC_W;

   logic signed [CW-1:0] x_ff [NSTEP];
   logic signed [CW-1:0] y_ff [NSTEP];
   logic signed [CW-1:0] z_ff [NSTEP];
   logic                 neg_ff [NSTEP];

   eulq_pkg::sincos_type sc_in, sc_ff;

   for (genvar i = 0; i < NSTEP; i++) begin : g_step
      logic signed [CW-1:0] xs, ys, zs;
      logic                 ns;
      logic signed [CW-1:0] x_in, y_in, z_in;

      if (i == 0) begin : g_first
         assign xs = eulq_pkg::CORDIC_X0;
         assign ys = '0;
         assign zs = CW'(z);
         assign ns = neg;
      end else begin : g_next
         assign xs = x_ff[i-1];
         assign ys = y_ff[i-1];
         assign zs = z_ff[i-1];
         assign ns = neg_ff[i-1];
      end

      // one micro-rotation toward zero residual angle
      always_comb begin
         if (!zs[CW-1]) begin
            x_in = xs - (ys >>> i);
            y_in = ys + (xs >>> i);
            z_in = zs - eulq_pkg::atan_turn(5'(i));
         end else begin
            x_in = xs + (ys >>> i);
            y_in = ys - (xs >>> i);
            z_in = zs + eulq_pkg::atan_turn(5'(i));
         end
      end

      always_ff @(posedge clock) begin
         if (en[i]) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            z_ff[i] <= z_in;
            neg_ff[i] <= ns;
         end
      end
   end

   // undo the quadrant fold
   always_comb begin
      if (neg_ff[NSTEP-1]) begin
         sc_in.sine = eulq_pkg::SC_W'(-y_ff[NSTEP-1]);
         sc_in.cosine = eulq_pkg::SC_W'(-x_ff[NSTEP-1]);
      end else begin
         sc_in.sine = eulq_pkg::SC_W'(y_ff[NSTEP-1]);
         sc_in.cosine = eulq_pkg::SC_W'(x_ff[NSTEP-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[NSTEP]) begin
         sc_ff <= sc_in;
      end
   end

   assign sc = sc_ff;

endmodule

// ===== rtl/eulq_qmul.sv =====
module eulq_qmul #(
   parameter int FRAC_BITS = 14
) (
   input  logic                                 clock,
   input  logic [4:0]                           en,
   input  eulq_pkg::sincos_type                 sc_x,
   input  eulq_pkg::sincos_type                 sc_y,
   input  eulq_pkg::sincos_type                 sc_z,
   output logic signed [eulq_pkg::QUAT_W-1:0]   quat_x,
   output logic signed [eulq_pkg::QUAT_W-1:0]   quat_y,
   output logic signed [eulq_pkg::QUAT_W-1:0]   quat_z,
   output logic signed [eulq_pkg::QUAT_W-1:0]   quat_w
);

   localparam int SW = eulq_pkg::SC_W;
   localparam int QW = eulq_pkg::QUAT_W;
   localparam int OUT_SH = 2 * eulq_pkg::INT_FRAC - FRAC_BITS;
   localparam logic signed [63:0] LIM =
      ((64'sd1 <<< FRAC_BITS) > 64'sd32767) ? 64'sd32767 : (64'sd1 <<< FRAC_BITS);
   // components x and z take the difference, y and w the sum
   localparam logic [3:0] SUB_MASK = 4'b0101;

   // round to nearest, ties away from zero
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int sh);
      logic signed [63:0] half;
      half = 64'sd1 <<< (sh - 1);
      if (v[63]) begin
         half = half - 64'sd1;
      end
      return (v + half) >>> sh;
   endfunction

   logic signed [63:0]   p_in [4];
   logic signed [63:0]   p_ff [4];
   eulq_pkg::sincos_type z1_ff, z2_ff;
   logic signed [SW-1:0] t_in [4];
   logic signed [SW-1:0] t_ff [4];
   logic signed [63:0]   a_in [4];
   logic signed [63:0]   b_in [4];
   logic signed [63:0]   a_ff [4];
   logic signed [63:0]   b_ff [4];
   logic signed [63:0]   s_in [4];
   logic signed [63:0]   s_ff [4];
   logic signed [63:0]   r_v [4];
   logic signed [QW-1:0] q_in [4];
   logic signed [QW-1:0] q_ff [4];

   // stage 1: qy * qx partial products (index 2 holds sy*sx before negation)
   always_comb begin
      p_in[0] = 64'(sc_y.cosine) * 64'(sc_x.sine);
      p_in[1] = 64'(sc_y.sine) * 64'(sc_x.cosine);
      p_in[2] = 64'(sc_y.sine) * 64'(sc_x.sine);
      p_in[3] = 64'(sc_y.cosine) * 64'(sc_x.cosine);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         p_ff <= p_in;
         z1_ff <= sc_z;
      end
   end

   // stage 2: back to Q30
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         t_in[k] = SW'(round_shift(p_ff[k], eulq_pkg::INT_FRAC));
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         t_ff <= t_in;
         z2_ff <= z1_ff;
      end
   end

   // stage 3: qz * t, the negated z term folded into the signs
   always_comb begin
      a_in[0] = 64'(z2_ff.cosine) * 64'(t_ff[0]);
      b_in[0] = 64'(z2_ff.sine) * 64'(t_ff[1]);
      a_in[1] = 64'(z2_ff.cosine) * 64'(t_ff[1]);
      b_in[1] = 64'(z2_ff.sine) * 64'(t_ff[0]);
      a_in[2] = 64'(z2_ff.sine) * 64'(t_ff[3]);
      b_in[2] = 64'(z2_ff.cosine) * 64'(t_ff[2]);
      a_in[3] = 64'(z2_ff.cosine) * 64'(t_ff[3]);
      b_in[3] = 64'(z2_ff.sine) * 64'(t_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   // stage 4: sums
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         s_in[k] = SUB_MASK[k] ? (a_ff[k] - b_ff[k]) : (a_ff[k] + b_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s_ff <= s_in;
      end
   end

   // stage 5: round and clamp into the output register
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         r_v[k] = round_shift(s_ff[k], OUT_SH);
         if (r_v[k] > LIM) begin
            r_v[k] = LIM;
         end else if (r_v[k] < -LIM) begin
            r_v[k] = -LIM;
         end
         q_in[k] = QW'(r_v[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         q_ff <= q_in;
      end
   end

   assign quat_x = q_ff[0];
   assign quat_y = q_ff[1];
   assign quat_z = q_ff[2];
   assign quat_w = q_ff[3];

endmodule

// ===== rtl/euler_xyz_to_quaternion.sv =====
// Euler X-Y-Z angles (1/64 degree, signed) to the rotation quaternion qz*qy*qx in
// Q2.14 by default (FRAC_BITS fraction bits), rounded to nearest and clamped to
// +-1.0. Each half angle is turned into a binary angle, folded into +-90 degrees and
// run through its own CORDIC of CORDIC_STEPS stages (at most 24); two rounds of
// multiplies then form the Hamilton product. One beat is accepted every cycle while
// req_tready is high. Each result passes through three stages
// of angle conversion, one per micro-rotation plus one for the quadrant fix-up,
// and five for the products, sums and final rounding. A stalled output holds only
// the stages behind it that are full; empty stages keep filling, so req_tready
// falls only once every stage holds a beat.
module euler_xyz_to_quaternion #(
   parameter int CORDIC_STEPS = 16,
   parameter int FRAC_BITS = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // angle_x, angle_y, angle_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata   // quat_x, quat_y, quat_z, quat_w
);

   localparam int NSTEP = (CORDIC_STEPS > eulq_pkg::ATAN_LEN) ? eulq_pkg::ATAN_LEN
                                                              : CORDIC_STEPS;
   localparam int ANG_STAGES = 3;
   localparam int COR_STAGES = NSTEP + 1;
   localparam int MUL_STAGES = 5;
   localparam int NST = ANG_STAGES + COR_STAGES + MUL_STAGES;
   localparam int COR_LO = ANG_STAGES;
   localparam int MUL_LO = ANG_STAGES + COR_STAGES;
   localparam logic [NST-1:0] ONES = '1;
   localparam int QLIM = ((1 << FRAC_BITS) > 32767) ? 32767 : (1 << FRAC_BITS);

   logic [NST-1:0] valid_in, valid_ff;
   logic [NST-1:0] adv;
   logic [NST-1:0] shifted;

   logic signed [eulq_pkg::TURN_W-1:0] z_x, z_y, z_z;
   logic                               neg_x, neg_y, neg_z;
   eulq_pkg::sincos_type               sc_x, sc_y, sc_z;
   logic signed [eulq_pkg::QUAT_W-1:0] quat_x, quat_y, quat_z, quat_w;

   // a stage moves when some stage at or after it is empty, or the output beat leaves
   always_comb begin
      for (int i = 0; i < NST; i++) begin
         adv[i] = rsp_tready || !(&(valid_ff | (ONES >> (NST - i))));
      end
      shifted = {valid_ff[NST-2:0], req_tvalid};
      valid_in = (adv & shifted) | (~adv & valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = valid_ff[NST-1];

   eulq_angle u_angle_x (
      .clock (clock),
      .en    (adv[2:0]),
      .angle (signed'(req_tdata[15:0])),
      .z     (z_x),
      .neg   (neg_x)
   );

   eulq_angle u_angle_y (
      .clock (clock),
      .en    (adv[2:0]),
      .angle (signed'(req_tdata[31:16])),
      .z     (z_y),
      .neg   (neg_y)
   );

   eulq_angle u_angle_z (
      .clock (clock),
      .en    (adv[2:0]),
      .angle (signed'(req_tdata[47:32])),
      .z     (z_z),
      .neg   (neg_z)
   );

   eulq_cordic #(.NSTEP(NSTEP)) u_cordic_x (
      .clock (clock),
      .en    (adv[MUL_LO-1:COR_LO]),
      .z     (z_x),
      .neg   (neg_x),
      .sc    (sc_x)
   );

   eulq_cordic #(.NSTEP(NSTEP)) u_cordic_y (
      .clock (clock),
      .en    (adv[MUL_LO-1:COR_LO]),
      .z     (z_y),
      .neg   (neg_y),
      .sc    (sc_y)
   );

   eulq_cordic #(.NSTEP(NSTEP)) u_cordic_z (
      .clock (clock),
      .en    (adv[MUL_LO-1:COR_LO]),
      .z     (z_z),
      .neg   (neg_z),
      .sc    (sc_z)
   );

   eulq_qmul #(.FRAC_BITS(FRAC_BITS)) u_qmul (
      .clock  (clock),
      .en     (adv[NST-1:MUL_LO]),
      .sc_x   (sc_x),
      .sc_y   (sc_y),
      .sc_z   (sc_z),
      .quat_x (quat_x),
      .quat_y (quat_y),
      .quat_z (quat_z),
      .quat_w (quat_w)
   );

   assign rsp_tdata = {quat_w, quat_z, quat_y, quat_x};

`ifndef SYNTHESIS
   a_beat_count: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
         ($countones(valid_ff) + $past(rsp_tvalid && rsp_tready)
          == $past($countones(valid_ff)) + $past(req_tvalid && req_tready)))
      else $error("beats lost or duplicated in the pipeline");

   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (&valid_ff) && !rsp_tready)
      else $error("input stalled with a free stage");

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         ($signed(rsp_tdata[15:0]) <= QLIM) && ($signed(rsp_tdata[15:0]) >= -QLIM) &&
         ($signed(rsp_tdata[31:16]) <= QLIM) && ($signed(rsp_tdata[31:16]) >= -QLIM) &&
         ($signed(rsp_tdata[47:32]) <= QLIM) && ($signed(rsp_tdata[47:32]) >= -QLIM) &&
         ($signed(rsp_tdata[63:48]) <= QLIM) && ($signed(rsp_tdata[63:48]) >= -QLIM))
      else $error("quaternion component outside clamp range");
`endif

endmodule

// ===== tb/sv/euler_xyz_to_quaternion_tb.sv =====
module euler_xyz_to_quaternion_tb;

   localparam int STEPS = 16;
   localparam int FRAC = 14;
   localparam int RANDOM_BEATS = 1500;
   localparam int DRAIN_CYCLES = STEPS + 9 + 16;

   localparam longint MICRO_ANGLES [0:eulq_pkg::ATAN_LEN-1] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
      64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
      64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
   };

   typedef struct packed {
      logic signed [eulq_pkg::ANGLE_W-1:0] z;
      logic signed [eulq_pkg::ANGLE_W-1:0] y;
      logic signed [eulq_pkg::ANGLE_W-1:0] x;
   } euler_type;

   typedef struct packed {
      logic signed [eulq_pkg::QUAT_W-1:0] w;
      logic signed [eulq_pkg::QUAT_W-1:0] z;
      logic signed [eulq_pkg::QUAT_W-1:0] y;
      logic signed [eulq_pkg::QUAT_W-1:0] x;
   } quat_type;

   class quat_scoreboard;
      quat_type pending[$];
      int       failures = 0;

      function automatic longint round_off(longint v, int s);
         longint half;
         half = longint'(1) <<< (s - 1);
         if (v >= 0) return (v + half) >>> s;
         return -((-v + half) >>> s);
      endfunction

      // sine and cosine of half the angle, q30
      function automatic void half_sincos(longint a, output longint s, output longint c);
         longint mag, q, zs, z, x, y, dx, dy;
         logic [31:0] zu;
         bit flip;
         mag = (a < 0) ? -a : a;
         q = ((mag <<< 32) + 23040) / 46080;
         zs = (a < 0) ? -q : q;
         zu = zs[31:0];
         z = longint'($signed(zu));
         flip = 0;
         if (z > (longint'(1) <<< 30)) begin
            z -= longint'(1) <<< 31;
            flip = 1;
         end else if (z < -(longint'(1) <<< 30)) begin
            z += longint'(1) <<< 31;
            flip = 1;
         end
         x = 652032874;
         y = 0;
         for (int i = 0; i < STEPS && i < eulq_pkg::ATAN_LEN; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx;
               y += dy;
               z -= MICRO_ANGLES[i];
            end else begin
               x += dx;
               y -= dy;
               z += MICRO_ANGLES[i];
            end
         end
         s = flip ? -y : y;
         c = flip ? -x : x;
      endfunction

      function automatic logic signed [eulq_pkg::QUAT_W-1:0] to_component(longint v);
         longint r, lim;
         r = round_off(v, 2 * eulq_pkg::INT_FRAC - FRAC);
         lim = longint'(1) <<< FRAC;
         if (lim > 32767) lim = 32767;
         if (r > lim) r = lim;
         if (r < -lim) r = -lim;
         return r[eulq_pkg::QUAT_W-1:0];
      endfunction

      function void note_angles(euler_type a);
         longint sx, cx, sy, cy, sz, cz, tx, ty, tz, tw;
         quat_type q;
         half_sincos(longint'(a.x), sx, cx);
         half_sincos(longint'(a.y), sy, cy);
         half_sincos(longint'(a.z), sz, cz);
         tx = round_off(cy * sx, eulq_pkg::INT_FRAC);
         ty = round_off(sy * cx, eulq_pkg::INT_FRAC);
         tz = round_off(-(sy * sx), eulq_pkg::INT_FRAC);
         tw = round_off(cy * cx, eulq_pkg::INT_FRAC);
         q.x = to_component(cz * tx - sz * ty);
         q.y = to_component(cz * ty + sz * tx);
         q.z = to_component(cz * tz + sz * tw);
         q.w = to_component(cz * tw - sz * tz);
         pending.push_back(q);
      endfunction

      function void compare(string name, logic signed [eulq_pkg::QUAT_W-1:0] want,
                            logic signed [eulq_pkg::QUAT_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_quat(quat_type got);
         quat_type want;
         if (pending.size() == 0) begin
            $error("result beat with nothing outstanding: %h", got);
            failures++;
            return;
         end
         want = pending.pop_front();
         compare("quat_x", want.x, got.x);
         compare("quat_y", want.y, got.y);
         compare("quat_z", want.z, got.z);
         compare("quat_w", want.w, got.w);
      endfunction

      function int outstanding();
         return pending.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;  // angle_x, angle_y, angle_z
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;       // quat_x, quat_y, quat_z, quat_w

   quat_scoreboard sb = new();

   int          burst_left = 0;
   logic [31:0] ready_pattern = '1;
   int          ready_phase = 0;
   int          ready_span = 0;

   euler_xyz_to_quaternion #(
      .CORDIC_STEPS(STEPS),
      .FRAC_BITS(FRAC)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_angles(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_quat(rsp_tdata);
      end
   end

   // receiver stalls: free-flowing, random and mostly stalled stretches
   always @(posedge clock) begin
      if (ready_span == 0) begin
         case ($urandom_range(0, 2))
            0: ready_pattern = '1;
            1: ready_pattern = $urandom;
            default: ready_pattern = $urandom & $urandom & $urandom | 32'h1;
         endcase
         ready_span = $urandom_range(40, 300);
      end
      ready_span--;
      rsp_tready <= ready_pattern[ready_phase];
      ready_phase = (ready_phase + 1) % 32;
   end

   // bursts of random length separated by random gaps
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
   endtask

   task automatic send_angles(int ax, int ay, int az);
      euler_type a;
      pace();
      a.x = ax[eulq_pkg::ANGLE_W-1:0];
      a.y = ay[eulq_pkg::ANGLE_W-1:0];
      a.z = az[eulq_pkg::ANGLE_W-1:0];
      req_tvalid <= 1'b1;
      req_tdata <= a;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic int pick_angle();
      int kind;
      kind = $urandom_range(0, 9);
      if (kind < 6) return int'($urandom_range(0, 46080)) - 23040;
      // around multiples of a quarter turn and the fold boundary
      if (kind < 8)
         return (int'($urandom_range(0, 8)) - 4) * 5760 + int'($urandom_range(0, 6)) - 3;
      return int'($signed($urandom_range(0, 65535) - 32768));
   endfunction

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_angles(0, 0, 0);
      send_angles(23040, 23040, 23040);
      send_angles(-23040, -23040, -23040);
      send_angles(32767, -32768, 0);
      send_angles(-32768, 32767, -1);
      send_angles(5760, 0, 0);
      send_angles(0, 5760, 0);
      send_angles(0, 0, 5760);
      send_angles(11520, -11520, 11520);
      send_angles(11521, -11521, 11519);
      send_angles(-11519, 11519, -11521);
      send_angles(17280, -17280, 23040);
      send_angles(1, -1, 1);
      send_angles(21845, -21846, 21845);
      send_angles(-21846, 21845, -21846);
      send_angles(2880, 2880, 2880);
      send_angles(-5760, 11520, -17280);
      send_angles(23039, -23039, 64);
      send_angles(-32767, 32766, 23041);

      for (int i = 0; i < RANDOM_BEATS; i++)
         send_angles(pick_angle(), pick_angle(), pick_angle());
      req_tvalid <= 1'b0;

      while (sb.outstanding() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.failures == 0 && sb.outstanding() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("tb: failure");
      $finish;
   end

endmodule
